// ===== hw/rtl/rse_pkg.sv =====
// rse_pkg: shared types, constants and helper functions for the rpn stack evaluator
// used by every module of the block except rse_ram; depends on nothing

package rse_pkg;

    localparam int STACK_DEPTH   = 64;
    localparam int FRACTION_BITS = 16;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W  = $clog2(STACK_DEPTH);
    localparam int MAG_W  = 64;
    localparam int DIVD_W = DATA_W + FRACTION_BITS;
    localparam int DCNT_W = $clog2(DIVD_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ACT_PUSH = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_SUB  = 3'd2;
    localparam logic [2:0] ACT_MUL  = 3'd3;
    localparam logic [2:0] ACT_DIV  = 3'd4;
    localparam logic [2:0] ACT_END  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_EXCESS    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_ARITH = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] number;
    } tok_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] answer;
        logic                     finished;
    } res_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [2:0]               action;
        logic signed [DATA_W-1:0] number;
    } cmd_t;

    typedef struct packed {
        logic             busy;
        logic [2:0]       err;
        logic [CNT_W-1:0] cnt;
    } back_stat_t;

    function automatic logic [DATA_W-1:0] mag_of(logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] m;
        m = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
        return m;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_mag(logic [MAG_W-1:0] m, logic neg);
        logic signed [DATA_W-1:0] r;
        if (neg)
        begin
            if (m >= MAG_W'(64'h8000_0000))
                r = VAL_MIN;
            else
                r = -$signed(m[DATA_W-1:0]);
        end
        else
        begin
            if (m > MAG_W'(64'h7fff_ffff))
                r = VAL_MAX;
            else
                r = $signed(m[DATA_W-1:0]);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rpn_stack_evaluator.sv =====
// rpn_stack_evaluator: push, end and unused codes go through the command queue and the
// output register; add/sub take S_READ, S_FIN; multiply S_READ, S_MUL, S_FIN; divide
// S_READ, S_DIV (bit-serial divider), S_FIN; one push or end per cycle while no result
// stalls and no arithmetic is in flight; reset clears the stack count, the sticky error,
// the command queue and the output valid flag; stack memory is not cleared, entries are
// read only after being written; depends on rse_pkg, rse_front, rse_back

module rpn_stack_evaluator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_valid,
    output logic          tok_stall,
    input  rse_pkg::tok_t tok,
    output logic          res_valid,
    input  logic          res_stall,
    output rse_pkg::res_t res
);

    import rse_pkg::*;

    logic       q_valid;
    cmd_t       q_cmd;
    logic       q_pop;
    back_stat_t stat;

    rse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_valid(tok_valid),
        .tok_stall(tok_stall),
        .tok      (tok),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    rse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res),
        .stat     (stat)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.cnt <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_sticky_excess: assert property (@(posedge clk) disable iff (!rst_n)
        stat.err != ST_EXCESS)
        else $error("excess operands held as sticky error");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !res_valid)
        else $error("result pending while an operation is in flight");

    a_status_tracks_err: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.finished) |-> (res.status == stat.err))
        else $error("result status differs from sticky error");

endmodule

// ===== hw/rtl/rse_ram.sv =====
// rse_ram: generic single-write, single-read memory with registered read data
// standalone; no package dependency

module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rse_front.sv =====
// rse_front: accepts tokens, classifies them and queues commands for the back end
// depends on rse_pkg

module rse_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_valid,
    output logic          tok_stall,
    input  rse_pkg::tok_t tok,
    output logic          q_valid,
    output rse_pkg::cmd_t q_cmd,
    input  logic          q_pop
);

    import rse_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;
    cmd_t              cls;

    // classify the token
    always_comb
    begin
        cls.action = tok.action;
        cls.number = tok.number;
        unique case (tok.action)
            ACT_PUSH:                           cls.kind = KIND_PUSH;
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: cls.kind = KIND_ARITH;
            ACT_END:                            cls.kind = KIND_END;
            default:                            cls.kind = KIND_NOP;
        endcase
    end

    assign tok_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = tok_valid && !tok_stall;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_cmd     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ===== hw/rtl/rse_div.sv =====
// rse_div: iterative restoring divider, one quotient bit per cycle, saturating result
// depends on rse_pkg

module rse_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rse_pkg::DATA_W-1:0]        dend,
    input  logic [rse_pkg::DATA_W-1:0]        dsor,
    input  logic                              neg,
    output logic                              done,
    output logic signed [rse_pkg::DATA_W-1:0] quo
);

    import rse_pkg::*;

    logic [DIVD_W-1:0] q_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dsor_reg;
    logic              neg_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;

    assign shifted = {rem_reg, q_reg[DIVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= DIVD_W'(dend) << FRACTION_BITS;
            rem_reg  <= '0;
            dsor_reg <= dsor;
            neg_reg  <= neg;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIVD_W-2:0], ~diff[DATA_W+1]};
            if (!diff[DATA_W+1])
                rem_reg <= diff[DATA_W-1:0];
            else
                rem_reg <= shifted[DATA_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = sat_mag(MAG_W'(q_reg), neg_reg);

endmodule

// ===== hw/rtl/rse_back.sv =====
// rse_back: executes queued commands on the operand stack and registers the result
// depends on rse_pkg, rse_ram and rse_div

module rse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  rse_pkg::cmd_t       q_cmd,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output rse_pkg::res_t       res,
    output rse_pkg::back_stat_t stat
);

    import rse_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [2:0]               err_reg, err_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] tos_reg, tos_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [MAG_W-1:0]         prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic [2:0]               op_reg, op_next;
    res_t                     out_reg, out_next;

    logic                     out_free;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W-1:0]         cnt_m2;
    logic                     we;
    logic                     re;
    logic [DATA_W-1:0]        rdata;
    logic signed [DATA_W-1:0] lhs;
    logic signed [DATA_W:0]   sum;
    logic signed [DATA_W-1:0] top_val;
    logic                     div_start;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quo;

    assign cnt_m1   = cnt_reg - 1'b1;
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign out_free = !out_valid_reg || !res_stall;
    assign lhs      = $signed(rdata);
    assign top_val  = (cnt_reg != '0) ? tos_reg : '0;
    assign sum      = (op_reg == ACT_SUB) ? ({lhs[DATA_W-1], lhs} - {tos_reg[DATA_W-1], tos_reg})
                                          : ({lhs[DATA_W-1], lhs} + {tos_reg[DATA_W-1], tos_reg});

    // entries below the top of stack live in the ram, the top stays in tos_reg
    rse_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (we),
        .waddr(cnt_m1[PTR_W-1:0]),
        .wdata(tos_reg),
        .re   (re),
        .raddr(cnt_m2[PTR_W-1:0]),
        .rdata(rdata)
    );

    rse_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .dend (mag_of(lhs)),
        .dsor (mag_of(tos_reg)),
        .neg  (lhs[DATA_W-1] ^ tos_reg[DATA_W-1]),
        .done (div_done),
        .quo  (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        tos_next       = tos_reg;
        res_next       = res_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_next       = out_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        re             = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop             = 1'b1;
                    out_valid_next    = 1'b1;
                    out_next.finished = 1'b0;
                    out_next.status   = err_reg;
                    out_next.answer   = top_val;
                    unique case (q_cmd.kind)
                        KIND_END:
                        begin
                            out_next.finished = 1'b1;
                            out_next.answer   = '0;
                            priority if (err_reg != ST_OK)
                                out_next.status = err_reg;
                            else if (cnt_reg == '0)
                                out_next.status = ST_UNDERFLOW;
                            else if (cnt_reg > CNT_W'(1))
                                out_next.status = ST_EXCESS;
                            else
                            begin
                                out_next.status = ST_OK;
                                out_next.answer = tos_reg;
                            end
                            cnt_next = '0;
                            err_next = ST_OK;
                        end
                        KIND_PUSH:
                        begin
                            if (err_reg == ST_OK)
                            begin
                                if (cnt_reg == CNT_W'(STACK_DEPTH))
                                begin
                                    err_next        = ST_OVERFLOW;
                                    out_next.status = ST_OVERFLOW;
                                end
                                else
                                begin
                                    we              = (cnt_reg != '0);
                                    tos_next        = q_cmd.number;
                                    cnt_next        = cnt_reg + 1'b1;
                                    out_next.answer = q_cmd.number;
                                end
                            end
                        end
                        KIND_ARITH:
                        begin
                            if (err_reg == ST_OK)
                            begin
                                priority if (cnt_reg < CNT_W'(2))
                                begin
                                    err_next        = ST_UNDERFLOW;
                                    out_next.status = ST_UNDERFLOW;
                                end
                                else if (q_cmd.action == ACT_DIV && tos_reg == '0)
                                begin
                                    err_next        = ST_DIVZERO;
                                    out_next.status = ST_DIVZERO;
                                end
                                else
                                begin
                                    out_valid_next = 1'b0;
                                    re             = 1'b1;
                                    op_next        = q_cmd.action;
                                    state_next     = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                neg_next = lhs[DATA_W-1] ^ tos_reg[DATA_W-1];
                unique case (op_reg)
                    ACT_ADD, ACT_SUB:
                    begin
                        if (sum[DATA_W] != sum[DATA_W-1])
                            res_next = sum[DATA_W] ? VAL_MIN : VAL_MAX;
                        else
                            res_next = sum[DATA_W-1:0];
                        state_next = S_FIN;
                    end
                    ACT_MUL:
                    begin
                        prod_next  = MAG_W'(mag_of(lhs)) * MAG_W'(mag_of(tos_reg));
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                endcase
            end
            S_MUL:
            begin
                res_next   = sat_mag(prod_reg >> FRACTION_BITS, neg_reg);
                state_next = S_FIN;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quo;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    tos_next          = res_reg;
                    cnt_next          = cnt_m1;
                    out_valid_next    = 1'b1;
                    out_next.status   = ST_OK;
                    out_next.answer   = res_reg;
                    out_next.finished = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg  <= tos_next;
        res_reg  <= res_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        op_reg   <= op_next;
        out_reg  <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.err  = err_reg;
    assign stat.cnt  = cnt_reg;

endmodule
